// File: sv/utf8_to_utf32_decoder_assert.svh
// ----------------------------------------------------------------------------
// utf8 decoder assertion macros
// shared property wrappers clocked on aclk, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF32_DECODER_ASSERT_SVH
`define UTF8_TO_UTF32_DECODER_ASSERT_SVH

// condition holds in the same cycle as the antecedent
`define U8U_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the antecedent
`define U8U_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/u8u32_pkg.sv
// ----------------------------------------------------------------------------
// u8u32_pkg
// types and byte-class constants for the utf8 to utf32 decoder
// ----------------------------------------------------------------------------
package u8u32_pkg;

    localparam int CP_W = 21;

    // lead and continuation byte class masks / patterns
    localparam logic [7:0] MASK_TOP1   = 8'b1000_0000;
    localparam logic [7:0] MASK_TOP2   = 8'b1100_0000;
    localparam logic [7:0] MASK_TOP3   = 8'b1110_0000;
    localparam logic [7:0] MASK_TOP4   = 8'b1111_0000;
    localparam logic [7:0] MASK_TOP5   = 8'b1111_1000;
    localparam logic [7:0] PAT_CONT    = 8'b1000_0000;
    localparam logic [7:0] PAT_LEAD2   = 8'b1100_0000;
    localparam logic [7:0] PAT_LEAD3   = 8'b1110_0000;
    localparam logic [7:0] PAT_LEAD4   = 8'b1111_0000;

    // payload masks
    localparam logic [7:0] PAY_LEAD2   = 8'b0001_1111;
    localparam logic [7:0] PAY_LEAD3   = 8'b0000_1111;
    localparam logic [7:0] PAY_LEAD4   = 8'b0000_0111;
    localparam logic [7:0] PAY_CONT    = 8'b0011_1111;

    typedef enum logic [1:0] {
        ST_CODE  = 2'd0,
        ST_ERROR = 2'd1,
        ST_END   = 2'd2
    } status_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        status_t         status;
        logic            end_of_string;
    } result_t;

    // handshake between core and pipeline stages
    typedef struct packed {
        logic consume;
        logic load;
    } step_ctrl_t;

endpackage

// File: sv/u8u32_in_stage.sv
// ----------------------------------------------------------------------------
// u8u32_in_stage
// input register holding one byte beat until the core consumes it
// ----------------------------------------------------------------------------
module u8u32_in_stage
    import u8u32_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] byte_data,
    output logic       byte_last
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    assign s_ready = !valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data_byte;
            last_reg <= s_last_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;
    assign byte_last  = last_reg;

endmodule

// File: sv/u8u32_core.sv
// ----------------------------------------------------------------------------
// u8u32_core
// decode state and single-pass byte step logic
// ----------------------------------------------------------------------------
module u8u32_core
    import u8u32_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    input  logic       byte_last,
    input  logic       out_free,
    output step_ctrl_t ctrl,
    output result_t    res
);

    logic [1:0]      rem_reg,    rem_next;
    logic [CP_W-1:0] acc_reg,    acc_next;
    logic            halted_reg, halted_next;
    logic            emit;
    logic [CP_W-1:0] acc_shift;

    assign acc_shift = {acc_reg[CP_W-7:0], byte_data[5:0] & PAY_CONT[5:0]};

    always_comb begin
        rem_next    = rem_reg;
        acc_next    = acc_reg;
        halted_next = halted_reg;
        emit        = 1'b0;
        res         = '{code_point: '0, status: ST_ERROR, end_of_string: 1'b1};

        if (halted_reg) begin
            emit       = byte_last;
            res.status = ST_END;
        end else if (rem_reg == 2'd0) begin
            if ((byte_data & MASK_TOP1) == 8'h00) begin
                emit = 1'b1;
                res  = '{code_point: CP_W'(byte_data), status: ST_CODE,
                         end_of_string: byte_last};
            end else if ((byte_data & MASK_TOP3) == PAT_LEAD2) begin
                acc_next = CP_W'(byte_data & PAY_LEAD2);
                rem_next = 2'd1;
                emit     = byte_last;
            end else if ((byte_data & MASK_TOP4) == PAT_LEAD3) begin
                acc_next = CP_W'(byte_data & PAY_LEAD3);
                rem_next = 2'd2;
                emit     = byte_last;
            end else if ((byte_data & MASK_TOP5) == PAT_LEAD4) begin
                acc_next = CP_W'(byte_data & PAY_LEAD4);
                rem_next = 2'd3;
                emit     = byte_last;
            end else begin
                // stray continuation or 11111xxx in lead position
                halted_next       = 1'b1;
                emit              = 1'b1;
                res.end_of_string = byte_last;
            end
        end else if ((byte_data & MASK_TOP2) == PAT_CONT) begin
            rem_next = rem_reg - 2'd1;
            if (rem_reg == 2'd1) begin
                emit     = 1'b1;
                res      = '{code_point: acc_shift, status: ST_CODE,
                             end_of_string: byte_last};
                acc_next = '0;
            end else begin
                acc_next = acc_shift;
                emit     = byte_last;  // truncated when string ends here
            end
        end else begin
            // broken sequence, byte is not retried as a lead
            halted_next       = 1'b1;
            rem_next          = 2'd0;
            acc_next          = '0;
            emit              = 1'b1;
            res.end_of_string = byte_last;
        end

        if (byte_last) begin
            rem_next    = 2'd0;
            acc_next    = '0;
            halted_next = 1'b0;
        end
    end

    assign ctrl.consume = byte_valid && (out_free || !emit);
    assign ctrl.load    = byte_valid && emit && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg    <= 2'd0;
            acc_reg    <= '0;
            halted_reg <= 1'b0;
        end else if (ctrl.consume) begin
            rem_reg    <= rem_next;
            acc_reg    <= acc_next;
            halted_reg <= halted_next;
        end
    end

`include "utf8_to_utf32_decoder_assert.svh"

    `U8U_ASSERT_NEXT(a_last_clears, ctrl.consume && byte_last,
        rem_reg == 2'd0 && acc_reg == '0 && !halted_reg, "state not cleared at string end")
    `U8U_ASSERT_SAME(a_halt_idle, halted_reg, rem_reg == 2'd0,
        "halted with a sequence open")
    `U8U_ASSERT_SAME(a_acc_idle, rem_reg == 2'd0, acc_reg == '0,
        "accumulator not empty between sequences")
    `U8U_ASSERT_SAME(a_end_zero, ctrl.load && res.status == ST_END,
        res.code_point == '0 && res.end_of_string, "end result carries data")

endmodule

// File: sv/u8u32_out_stage.sv
// ----------------------------------------------------------------------------
// u8u32_out_stage
// result register feeding the m_ channel
// ----------------------------------------------------------------------------
module u8u32_out_stage
    import u8u32_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  result_t           res,
    output logic              out_free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CP_W-1:0]   m_code_point,
    output logic [1:0]        m_status,
    output logic              m_end_of_string
);

    logic    valid_reg;
    result_t res_reg;

    assign out_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid         = valid_reg;
    assign m_code_point    = res_reg.code_point;
    assign m_status        = res_reg.status;
    assign m_end_of_string = res_reg.end_of_string;

endmodule

// File: sv/utf8_to_utf32_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder
// streaming utf8 byte to utf32 code point decoder
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one utf8 byte per beat, s_last_byte marks the final
//   byte of a string. m_ channel gives zero or one result beat per byte:
//   a code point (status 0), an error for a bad or truncated sequence
//   (status 1) or a plain end marker after an earlier error (status 2).
//   the final byte of a string always yields a beat with m_end_of_string.
// order: an accepted byte is first held in the input register; its result
//   is loaded into the result register when the core consumes the byte,
//   and m_ is driven from that register.
// throughput: one byte per cycle unless a result waits on m_ready; the byte
//   step is a single shallow pass of class decode plus 6-bit accumulator shift.
// stall: while m_ready is low and a result is held, a byte that makes no
//   result still passes; one that makes a result waits in the input
//   register, and s_ready drops only when that register cannot drain.
// reset: aresetn low clears both pipeline valids and the decode state
//   (no open sequence, not halted); no beat is lost or invented after it.
// ----------------------------------------------------------------------------
module utf8_to_utf32_decoder
    import u8u32_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_data_byte,
    input  logic              s_last_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CP_W-1:0]   m_code_point,
    output logic [1:0]        m_status,
    output logic              m_end_of_string
);

    // input register to core
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       byte_last;

    // core to result register
    step_ctrl_t ctrl;
    result_t    res;
    logic       out_free;

    u8u32_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .take        (ctrl.consume),
        .byte_valid  (byte_valid),
        .byte_data   (byte_data),
        .byte_last   (byte_last)
    );

    // decode state lives here; advances only when the held byte is consumed
    u8u32_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_last  (byte_last),
        .out_free   (out_free),
        .ctrl       (ctrl),
        .res        (res)
    );

    u8u32_out_stage u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (ctrl.load),
        .res             (res),
        .out_free        (out_free),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_point    (m_code_point),
        .m_status        (m_status),
        .m_end_of_string (m_end_of_string)
    );

endmodule
